FILE: sv/bgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

    localparam int unsigned TimeW   = 16;
    localparam int unsigned EventW  = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned InDataW  = 24;
    localparam int unsigned OutDataW = 8;

    typedef logic [TimeW-1:0] time_ms_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOUCH_MS  = 2'd0,
        CFG_SLIP_MS   = 2'd1,
        CFG_LONG_MS   = 2'd2,
        CFG_DOUBLE_MS = 2'd3
    } cfg_idx_t;

    localparam time_ms_t TouchMsRst  = 16'd20;
    localparam time_ms_t SlipMsRst   = 16'd20;
    localparam time_ms_t LongMsRst   = 16'd800;
    localparam time_ms_t DoubleMsRst = 16'd220;

    typedef struct packed {
        time_ms_t touch_ms;
        time_ms_t slip_ms;
        time_ms_t long_press_ms;
        time_ms_t double_click_ms;
    } bgd_cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_TOUCH    = 3'd1,
        PH_PRESS    = 3'd2,
        PH_SLIP     = 3'd3,
        PH_RELEASE  = 3'd4,
        PH_PRESS2   = 3'd5,
        PH_RELEASE2 = 3'd6,
        PH_DRAIN    = 3'd7
    } phase_t;

    typedef enum logic [EventW-1:0] {
        EV_NONE       = 3'd0,
        EV_DOWN       = 3'd1,
        EV_UP         = 3'd2,
        EV_CLICK      = 3'd3,
        EV_DOUBLE     = 3'd4,
        EV_LONG       = 3'd5,
        EV_CLICK_LONG = 3'd6
    } event_t;

endpackage

FILE: sv/button_gesture_detector_top.sv
`timescale 1ns / 1ps
// an accepted item loads the input register, then the result register once the output side can take it
// throughput: one item per cycle unless m_tready stalls; the phase update is a single pass between the two registers
// a stalled result holds the input register, so at most two items are in flight
// reset: synchronous active-low aresetn clears both valid flags and the phase to idle,
// and loads the thresholds with 20, 20, 800 and 220 ms
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// Debounced click, double click and long press detection on a sampled button.
// ----------------------------------------------------------------------------
module button_gesture_detector_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bgd_pkg::InDataW-1:0]   s_tdata,   // [0] pressed, [16:1] now_ms
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bgd_pkg::OutDataW-1:0]  m_tdata,   // [2:0] event_code
    input  logic                          cfg_we,
    input  logic [bgd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bgd_pkg::TimeW-1:0]     cfg_wdata
);
    import bgd_pkg::*;

    bgd_cfg_t cfg;

    logic     in_valid_reg;
    logic     in_valid_next;
    logic     pressed_reg;
    time_ms_t now_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    event_t   event_reg;
    event_t   event_code;
    logic     out_ready;
    logic     advance;
    logic     s_fire;

    bgd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bgd_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .pressed    (pressed_reg),
        .now_ms     (now_reg),
        .cfg        (cfg),
        .event_code (event_code)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pressed_reg <= s_tdata[0];
            now_reg     <= s_tdata[TimeW:1];
        end
        if (advance) begin
            event_reg <= event_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-EventW){1'b0}}, event_reg};

    // a full input stage that cannot move must refuse new items
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_ready) |-> !s_tready)
        else $error("input accepted while input stage stalled");

    // every processed item shows up as a result on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item produced no result");

    // the code 7 is never produced
    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[EventW-1:0] != 3'd7))
        else $error("invalid event code");

endmodule

FILE: sv/bgd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// Timing threshold registers, written through a plain write port.
// ----------------------------------------------------------------------------
module bgd_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [bgd_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [bgd_pkg::TimeW-1:0] cfg_wdata,
    output bgd_pkg::bgd_cfg_t         cfg
);
    import bgd_pkg::*;

    bgd_cfg_t cfg_reg;
    bgd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TOUCH_MS:  cfg_next.touch_ms        = cfg_wdata;
                CFG_SLIP_MS:   cfg_next.slip_ms         = cfg_wdata;
                CFG_LONG_MS:   cfg_next.long_press_ms   = cfg_wdata;
                CFG_DOUBLE_MS: cfg_next.double_click_ms = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_ms        <= TouchMsRst;
            cfg_reg.slip_ms         <= SlipMsRst;
            cfg_reg.long_press_ms   <= LongMsRst;
            cfg_reg.double_click_ms <= DoubleMsRst;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/bgd_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_fsm
// Gesture phase machine with time mark; gives one event per step.
// ----------------------------------------------------------------------------
module bgd_fsm (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step,
    input  logic                      pressed,
    input  logic [bgd_pkg::TimeW-1:0] now_ms,
    input  bgd_pkg::bgd_cfg_t         cfg,
    output bgd_pkg::event_t           event_code
);
    import bgd_pkg::*;

    phase_t   phase_reg;
    phase_t   phase_next;
    time_ms_t mark_reg;
    time_ms_t mark_next;
    time_ms_t elapsed;
    event_t   ev;

    // wraps modulo 2^16
    assign elapsed = now_ms - mark_reg;

    always_comb begin
        phase_next = phase_reg;
        mark_next  = mark_reg;
        ev         = EV_NONE;
        unique case (phase_reg)
            PH_IDLE: begin
                if (pressed) begin
                    phase_next = PH_TOUCH;
                    mark_next  = now_ms;
                end
            end
            PH_TOUCH: begin
                if (!pressed) begin
                    phase_next = PH_IDLE;
                end else if (elapsed > cfg.touch_ms) begin
                    phase_next = PH_PRESS;
                    ev         = EV_DOWN;
                end
            end
            PH_PRESS: begin
                if (pressed) begin
                    if (elapsed >= cfg.long_press_ms) begin
                        phase_next = PH_DRAIN;
                        ev         = EV_LONG;
                    end
                end else begin
                    phase_next = PH_SLIP;
                    mark_next  = now_ms;
                end
            end
            PH_SLIP: begin
                // repress keeps the slip mark
                if (pressed) begin
                    phase_next = PH_PRESS;
                end else if (elapsed > cfg.slip_ms) begin
                    phase_next = PH_RELEASE;
                    ev         = EV_UP;
                end
            end
            PH_RELEASE: begin
                if (pressed) begin
                    phase_next = PH_PRESS2;
                    mark_next  = now_ms;
                    ev         = EV_DOWN;
                end else if (elapsed > cfg.double_click_ms) begin
                    phase_next = PH_IDLE;
                    ev         = EV_CLICK;
                end
            end
            PH_PRESS2: begin
                if (pressed) begin
                    if (elapsed >= cfg.long_press_ms) begin
                        phase_next = PH_DRAIN;
                        ev         = EV_CLICK_LONG;
                    end
                end else begin
                    phase_next = PH_RELEASE2;
                    ev         = EV_UP;
                end
            end
            PH_RELEASE2: begin
                if (!pressed) begin
                    phase_next = PH_IDLE;
                    ev         = EV_DOUBLE;
                end
            end
            PH_DRAIN: begin
                if (!pressed) begin
                    phase_next = PH_IDLE;
                    ev         = EV_UP;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (step) begin
            phase_reg <= phase_next;
        end
    end

    // mark is always written before a phase that reads it
    always_ff @(posedge aclk) begin
        if (step) begin
            mark_reg <= mark_next;
        end
    end

    assign event_code = ev;

endmodule
